// ----- rtl/ffha_pkg.sv -----
// shared types and constants for the first-fit heap allocator
package ffha_pkg;

  localparam int unsigned HeapBytes   = 4096;
  localparam int unsigned HeaderBytes = 16;

  // heap offset, block size, pointer that may reach the heap end, and sum width
  localparam int unsigned OffW  = $clog2(HeapBytes);
  localparam int unsigned SizeW = 13;
  localparam int unsigned PtrW  = OffW + 1;
  localparam int unsigned SumW  = PtrW + 1;
  localparam int unsigned WordW = SizeW + 1;

  typedef enum logic [2:0] {
    ST_WHOLE   = 3'd0,
    ST_SPLIT   = 3'd1,
    ST_NOMEM   = 3'd2,
    ST_FREED   = 3'd3,
    ST_IGNORED = 3'd4
  } ffha_status_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_WALK_START,
    OP_WALK_STEP,
    OP_WR_SPLIT,
    OP_WR_TAKE,
    OP_WR_FREE,
    OP_COAL_START,
    OP_COAL_STEP
  } ffha_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_WALK,
    S_A_SPLIT,
    S_A_MARK,
    S_F_WALK,
    S_C_START,
    S_C_RUN,
    S_RESP
  } ffha_state_e;

  typedef struct packed {
    ffha_op_e     op;
    logic         set_res;
    ffha_status_e res_code;
  } ffha_cmd_t;

  typedef struct packed {
    logic probe_end;
    logic fits;
    logic split;
    logic data_eq;
    logic data_gt;
    logic nx_end;
    logic c0_end;
  } ffha_stat_t;

endpackage

// ----- rtl/ffha_dp.sv -----
// datapath: block store, probe and current block registers, result registers
module ffha_dp
  import ffha_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ffha_cmd_t           cmd_i,
  input  logic [SizeW-1:0]    alloc_bytes_i,
  input  logic [OffW-1:0]     free_offset_i,
  output ffha_stat_t          stat_o,
  output logic [2:0]          status_o,
  output logic [OffW-1:0]     data_offset_o
);

  // headers at offsets other than zero; offset zero lives in flops
  logic [WordW-1:0] mem [HeapBytes];
  logic [WordW-1:0] mem_q;

  logic [SizeW-1:0] size0_q;
  logic             free0_q;

  logic [SizeW-1:0] bytes_q;
  logic [OffW-1:0]  target_q;

  logic [PtrW-1:0]  probe_off_q;
  logic             probe_zero_q;
  logic             probe_end_q;

  logic [PtrW-1:0]  off_q;
  logic [SizeW-1:0] cur_size_q;
  logic             cur_free_q;

  ffha_status_e     res_status_q;
  logic [OffW-1:0]  res_data_q;

  logic [SizeW-1:0] probe_size;
  logic             probe_free;
  logic [SumW-1:0]  nx_probe;
  logic [SumW-1:0]  c0_nx;
  logic [SumW-1:0]  data_pos;
  logic [SizeW-1:0] rem;
  logic [SumW-1:0]  split_pos;
  logic             merge;
  logic [SizeW-1:0] merged_size;

  logic             rd_en;
  logic [OffW-1:0]  rd_addr;
  logic             wr_en;
  logic [PtrW-1:0]  wr_addr;
  logic [WordW-1:0] wr_word;

  assign probe_size = probe_zero_q ? size0_q : mem_q[SizeW-1:0];
  assign probe_free = probe_zero_q ? free0_q : mem_q[SizeW];

  assign nx_probe  = SumW'(probe_off_q) + SumW'(HeaderBytes) + SumW'(probe_size);
  assign c0_nx     = SumW'(HeaderBytes) + SumW'(size0_q);
  assign data_pos  = SumW'(probe_off_q) + SumW'(HeaderBytes);
  assign rem       = probe_size - bytes_q;
  assign split_pos = data_pos + SumW'(bytes_q);

  assign merge       = cur_free_q && probe_free;
  assign merged_size = cur_size_q + probe_size + SizeW'(HeaderBytes);

  always_comb begin
    stat_o.probe_end = probe_end_q;
    stat_o.fits      = probe_free && (probe_size >= bytes_q);
    stat_o.split     = stat_o.fits && (rem > SizeW'(HeaderBytes));
    stat_o.data_eq   = (data_pos == SumW'(target_q));
    stat_o.data_gt   = (data_pos > SumW'(target_q));
    stat_o.nx_end    = (nx_probe >= SumW'(HeapBytes));
    stat_o.c0_end    = (c0_nx >= SumW'(HeapBytes));
  end

  // read and write port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = nx_probe[OffW-1:0];
    wr_en   = 1'b0;
    wr_addr = probe_off_q;
    wr_word = {1'b0, probe_size};
    case (cmd_i.op)
      OP_WALK_STEP: rd_en = 1'b1;
      OP_COAL_START: begin
        rd_en   = 1'b1;
        rd_addr = c0_nx[OffW-1:0];
      end
      OP_COAL_STEP: begin
        rd_en   = 1'b1;
        wr_en   = merge;
        wr_addr = off_q;
        wr_word = {1'b1, merged_size};
      end
      OP_WR_SPLIT: begin
        wr_en   = 1'b1;
        wr_addr = split_pos[PtrW-1:0];
        wr_word = {1'b1, rem - SizeW'(HeaderBytes)};
      end
      OP_WR_TAKE: begin
        wr_en   = 1'b1;
        wr_word = {1'b0, stat_o.split ? bytes_q : probe_size};
      end
      OP_WR_FREE: begin
        wr_en   = 1'b1;
        wr_word = {1'b1, probe_size};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && (wr_addr != '0)) begin
      mem[wr_addr[OffW-1:0]] <= wr_word;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size0_q <= SizeW'(HeapBytes - HeaderBytes);
      free0_q <= 1'b1;
    end else if (wr_en && (wr_addr == '0)) begin
      size0_q <= wr_word[SizeW-1:0];
      free0_q <= wr_word[SizeW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_off_q  <= '0;
      probe_zero_q <= 1'b1;
      probe_end_q  <= 1'b0;
      res_status_q <= ST_WHOLE;
      res_data_q   <= '0;
    end else begin
      case (cmd_i.op)
        OP_WALK_START: begin
          probe_off_q  <= '0;
          probe_zero_q <= 1'b1;
          probe_end_q  <= 1'b0;
        end
        OP_WALK_STEP: begin
          probe_off_q  <= nx_probe[PtrW-1:0];
          probe_zero_q <= 1'b0;
          probe_end_q  <= stat_o.nx_end;
        end
        OP_COAL_START: begin
          probe_off_q  <= c0_nx[PtrW-1:0];
          probe_zero_q <= 1'b0;
        end
        OP_COAL_STEP: begin
          probe_off_q  <= nx_probe[PtrW-1:0];
          probe_zero_q <= 1'b0;
        end
        default: ;
      endcase
      if (cmd_i.set_res) begin
        res_status_q <= cmd_i.res_code;
        if (cmd_i.res_code == ST_WHOLE || cmd_i.res_code == ST_SPLIT) begin
          res_data_q <= data_pos[OffW-1:0];
        end else begin
          res_data_q <= '0;
        end
      end
    end
  end

  // request fields and current coalesce block
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_WALK_START) begin
      bytes_q  <= alloc_bytes_i;
      target_q <= free_offset_i;
    end
    if (cmd_i.op == OP_COAL_START) begin
      off_q      <= '0;
      cur_size_q <= size0_q;
      cur_free_q <= free0_q;
    end else if (cmd_i.op == OP_COAL_STEP) begin
      if (merge) begin
        cur_size_q <= merged_size;
      end else begin
        off_q      <= probe_off_q;
        cur_size_q <= probe_size;
        cur_free_q <= probe_free;
      end
    end
  end

  assign status_o      = res_status_q;
  assign data_offset_o = res_data_q;

endmodule

// ----- rtl/ffha_ctrl.sv -----
// controller: request sequencing for allocate, free and coalesce
module ffha_ctrl
  import ffha_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic       req_type_i,
  input  ffha_stat_t stat_i,
  output ffha_cmd_t  cmd_o,
  output logic       busy,
  output logic       done_o
);

  ffha_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = req_type_i ? S_F_WALK : S_A_WALK;
        end
      end
      S_A_WALK: begin
        if (stat_i.probe_end) begin
          state_d = S_RESP;
        end else if (stat_i.fits) begin
          state_d = stat_i.split ? S_A_SPLIT : S_A_MARK;
        end
      end
      S_A_SPLIT: state_d = S_A_MARK;
      S_A_MARK:  state_d = S_RESP;
      S_F_WALK: begin
        if (stat_i.probe_end || stat_i.data_gt) begin
          state_d = S_RESP;
        end else if (stat_i.data_eq) begin
          state_d = S_C_START;
        end
      end
      S_C_START: state_d = stat_i.c0_end ? S_RESP : S_C_RUN;
      S_C_RUN: begin
        if (stat_i.nx_end) begin
          state_d = S_RESP;
        end
      end
      S_RESP:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.op       = OP_NOP;
    cmd_o.set_res  = 1'b0;
    cmd_o.res_code = ST_WHOLE;
    busy           = 1'b1;
    done_o         = 1'b0;
    case (state_q)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.op = OP_WALK_START;
        end
      end
      S_A_WALK: begin
        if (stat_i.probe_end) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = ST_NOMEM;
        end else if (!stat_i.fits) begin
          cmd_o.op = OP_WALK_STEP;
        end
      end
      S_A_SPLIT: cmd_o.op = OP_WR_SPLIT;
      S_A_MARK: begin
        cmd_o.op       = OP_WR_TAKE;
        cmd_o.set_res  = 1'b1;
        cmd_o.res_code = stat_i.split ? ST_SPLIT : ST_WHOLE;
      end
      S_F_WALK: begin
        if (stat_i.probe_end || stat_i.data_gt) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = ST_IGNORED;
        end else if (stat_i.data_eq) begin
          cmd_o.op       = OP_WR_FREE;
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = ST_FREED;
        end else begin
          cmd_o.op = OP_WALK_STEP;
        end
      end
      S_C_START: cmd_o.op = OP_COAL_START;
      S_C_RUN:   cmd_o.op = OP_COAL_STEP;
      S_RESP:    done_o   = 1'b1;
      default: ;
    endcase
  end

endmodule

// ----- rtl/first_fit_heap_allocator_top.sv -----
// top level of the first-fit heap allocator; one request at a time, busy until done_o
// allocate walks headers to the first free block that fits, writes a split header when
// the remainder exceeds a header, then marks the block taken; no memory past the chain end
// free walks to the matching data offset (ignored once past it or past the chain end), marks
// it free, then sweeps the chain merging free neighbours; the chain holds at most 256 blocks
// async active-low reset leaves one free block at offset zero; receiver cannot stall
module first_fit_heap_allocator_top
  import ffha_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // request side
  input  logic             start,
  output logic             busy,
  input  logic             req_type_i,
  input  logic [SizeW-1:0] alloc_bytes_i,
  input  logic [OffW-1:0]  free_offset_i,
  // result side
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [OffW-1:0]  data_offset_o
);

  // command and status between controller and datapath
  ffha_cmd_t  cmd;
  ffha_stat_t stat;

  // controller walks the chain, splits on allocate, sweeps merges after a matched free
  ffha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy       (busy),
    .done_o     (done_o)
  );

  // datapath holds the header store and the result registers
  ffha_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .alloc_bytes_i (alloc_bytes_i),
    .free_offset_i (free_offset_i),
    .stat_o        (stat),
    .status_o      (status_o),
    .data_offset_o (data_offset_o)
  );

endmodule
